// ----- rtl/pdme_pkg.sv -----
// Package for the pulse-distance pad/mouse line encoder.
// Holds item types, command codes, phase codes and segment lengths.
// No dependencies.
package pdme_pkg;

	localparam int PAD_BITS   = 12;
	localparam int MOUSE_BITS = 19;
	localparam int PHASE_W    = 7;
	localparam int DUR_W      = 15;

	// Commands
	localparam logic [1:0] CMD_TIMER  = 2'd0;
	localparam logic [1:0] CMD_REPORT = 2'd1;
	localparam logic [1:0] CMD_PINS   = 2'd2;

	// Frame phases
	localparam logic [PHASE_W-1:0] PH_IDLE      = 7'd0;
	localparam logic [PHASE_W-1:0] PH_PAD_START = 7'd1;
	localparam logic [PHASE_W-1:0] PH_PAD_BITS  = 7'd2;
	localparam logic [PHASE_W-1:0] PH_PAD_END   = PH_PAD_BITS + 7'(4 * PAD_BITS);
	localparam logic [PHASE_W-1:0] PH_PAD_STOP  = PH_PAD_END + 7'd1;
	localparam logic [PHASE_W-1:0] PH_REP       = PH_PAD_END + 7'd2;
	localparam logic [PHASE_W-1:0] PH_REP_PULSE = PH_REP + 7'd1;
	localparam logic [PHASE_W-1:0] PH_REP_STOP  = PH_REP + 7'd2;
	localparam logic [PHASE_W-1:0] PH_M_START   = PH_REP + 7'd4;
	localparam logic [PHASE_W-1:0] PH_M_BITS    = PH_M_START + 7'd1;
	localparam logic [PHASE_W-1:0] PH_M_STOP    = PH_M_BITS + 7'(2 * MOUSE_BITS);

	// Segment lengths, microseconds
	localparam logic [DUR_W-1:0] US_LEADER    = 15'd9000;
	localparam logic [DUR_W-1:0] US_LEAD_GAP  = 15'd4500;
	localparam logic [DUR_W-1:0] US_PULSE     = 15'd400;
	localparam logic [DUR_W-1:0] US_ONE       = 15'd1200;
	localparam logic [DUR_W-1:0] US_PAD_TAIL  = 15'd17300;
	localparam logic [DUR_W-1:0] US_REP_GAP   = 15'd2100;
	localparam logic [DUR_W-1:0] US_REP_TAIL  = 15'd24250;
	localparam logic [DUR_W-1:0] US_M_LEADER  = 15'd1100;
	localparam logic [DUR_W-1:0] US_M_GAP1    = 15'd375;
	localparam logic [DUR_W-1:0] US_M_LOW1    = 15'd500;
	localparam logic [DUR_W-1:0] US_M_LOW0    = 15'd138;
	localparam logic [DUR_W-1:0] US_M_GAP0    = 15'd735;
	localparam logic [DUR_W-1:0] US_M_STOP    = 15'd88;
	localparam logic [DUR_W-1:0] US_M_TAIL    = 15'd14000;
	localparam logic [DUR_W-1:0] US_RESET     = 15'd16;

	typedef struct packed {
		logic [1:0]        command;
		logic [5:0]        joystick_pins;
		logic [2:0]        button_bits;
		logic signed [7:0] move_x;
		logic signed [7:0] move_y;
	} evt_t;

	typedef struct packed {
		logic             line_low;
		logic [DUR_W-1:0] duration_us;
		logic             timer_run;
	} res_t;

endpackage

// ----- rtl/pulse_distance_pad_mouse_encoder_top.sv -----
// Top level of the pulse-distance pad/mouse line encoder.
// Holds the output register and skid stage; depends on pdme_pkg and pdme_core.
//
// Usage:
//   Input channel evt_valid / evt_stall / evt carries one event item:
//   a segment timer expiry, a mouse report or a joystick pin change.
//   Output channel res_valid / res_stall / res returns exactly one item per
//   event: the line level, the length of the next segment in microseconds
//   and whether the segment timer should run.
//   The result is registered into the output register, or into the skid
//   entry while the output is held. Throughput: one item per cycle while
//   the skid entry is empty; pdme_core computes all next state combinationally.
//   Stall: an output register plus a one-entry skid buffer. Events keep
//   being taken while a result waits; evt_stall rises only once the skid
//   entry is occupied, and drops as soon as the receiver takes a result.
//   Reset: asynchronous, active low. Frame state idle, sums, buttons and
//   pad code cleared, line released, held length 16 us, timer stopped, no
//   results pending.
module pulse_distance_pad_mouse_encoder_top import pdme_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic evt_valid,
	output logic evt_stall,
	input  evt_t evt,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	logic take;
	res_t res_next;

	logic out_valid_q;
	res_t out_q;
	logic skid_valid_q;
	res_t skid_q;

	// New events are held off only while the skid entry is full
	assign evt_stall = skid_valid_q;
	assign take      = evt_valid && !skid_valid_q;

	pdme_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.evt      (evt),
		.res_next (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || !res_stall) begin
			// output slot frees up: refill from skid first, else from core
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= take;
			end
		end else if (take) begin
			// output held by receiver: park the new result
			skid_valid_q <= 1'b1;
		end
	end

	// Payload registers, no reset
	always_ff @(posedge clk) begin
		if (!out_valid_q || !res_stall) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (take)
				out_q <= res_next;
		end else if (take) begin
			skid_q <= res_next;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

// ----- rtl/pdme_core.sv -----
// Frame sequencer and mouse accumulator of the pad/mouse line encoder.
// Updates all state on an accepted item; gives the resulting line state.
// Depends on pdme_pkg.
module pdme_core import pdme_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic take,
	input  evt_t evt,
	output res_t res_next
);

	logic [PHASE_W-1:0]    phase_q, phase_d;
	logic [PAD_BITS-1:0]   pad_code_q, pad_code_d;
	logic [MOUSE_BITS-1:0] mouse_frame_q, mouse_frame_d;
	logic [15:0]           sum_x_q, sum_x_d, sum_y_q, sum_y_d;
	logic [2:0]            buttons_q, buttons_d;
	logic                  line_q, line_d;
	logic [DUR_W-1:0]      dur_q, dur_d;
	logic                  run_q, run_d;

	// Step into the sums: +-1 whole, else halved toward zero
	function automatic logic [15:0] step_of(input logic signed [7:0] v);
		logic signed [8:0] w;
		w = 9'(v);
		if (v == 8'sd1 || v == -8'sd1)
			return 16'(signed'(v));
		w = (w + $signed({8'd0, v[7]})) >>> 1;
		return 16'(signed'(w));
	endfunction

	logic [5:0]            act;
	logic [PAD_BITS-1:0]   code;
	logic [7:0]            mx, my;
	logic [5:0]            ps, ms;
	logic [4:0]            pk;
	logic [3:0]            pk_w, pidx;
	logic                  pbit;
	logic [4:0]            midx;
	logic                  mbit;

	always_comb begin
		act  = ~evt.joystick_pins;
		code = (act != 6'd0) ? {1'b1, 3'b000, act, 2'b00} : '0;
		mx   = 8'd0 - sum_x_q[7:0];
		my   = 8'd0 - sum_y_q[7:0];

		ps   = 6'(phase_q - PH_PAD_BITS);
		pk   = ps[5:1];
		pk_w = (pk >= 5'(PAD_BITS)) ? 4'(pk - 5'(PAD_BITS)) : pk[3:0];
		pidx = 4'(PAD_BITS - 1) - pk_w;
		pbit = pad_code_q[pidx] ^ (pk >= 5'(PAD_BITS));

		ms   = 6'(phase_q - PH_M_BITS);
		midx = 5'(MOUSE_BITS - 1) - ms[5:1];
		mbit = mouse_frame_q[midx];
	end

	always_comb begin
		phase_d       = phase_q;
		pad_code_d    = pad_code_q;
		mouse_frame_d = mouse_frame_q;
		sum_x_d       = sum_x_q;
		sum_y_d       = sum_y_q;
		buttons_d     = buttons_q;
		line_d        = line_q;
		dur_d         = dur_q;
		run_d         = run_q;
		unique case (evt.command)
			CMD_REPORT: begin
				sum_x_d   = sum_x_q + step_of(evt.move_x);
				sum_y_d   = sum_y_q + step_of(evt.move_y);
				buttons_d = buttons_q | evt.button_bits;
				run_d     = 1'b1;
			end
			CMD_PINS: run_d = 1'b1;
			CMD_TIMER: begin
				if (run_q) begin
					priority if (phase_q == PH_IDLE) begin
						if (code != '0 || pad_code_q != '0) begin
							phase_d    = (code == pad_code_q) ? PH_REP : PH_PAD_START;
							pad_code_d = code;
							line_d     = 1'b1;
							dur_d      = US_LEADER;
						end else begin
							sum_x_d   = '0;
							sum_y_d   = '0;
							buttons_d = '0;
							if (buttons_q != 3'd0 || mx != 8'd0 || my != 8'd0) begin
								mouse_frame_d = {~buttons_q, mx, my};
								phase_d       = PH_M_START;
								line_d        = 1'b1;
								dur_d         = US_M_LEADER;
							end else begin
								run_d = 1'b0;
							end
						end
					end else if (phase_q == PH_PAD_START) begin
						line_d  = 1'b0;
						dur_d   = US_LEAD_GAP;
						phase_d = phase_q + 7'd1;
					end else if (phase_q < PH_PAD_END) begin
						line_d  = ~ps[0];
						dur_d   = (ps[0] && pbit) ? US_ONE : US_PULSE;
						phase_d = phase_q + 7'd1;
					end else if (phase_q == PH_PAD_END) begin
						line_d  = 1'b1;
						dur_d   = US_PULSE;
						phase_d = phase_q + 7'd1;
					end else if (phase_q == PH_PAD_STOP) begin
						line_d  = 1'b0;
						dur_d   = US_PAD_TAIL;
						phase_d = PH_IDLE;
					end else if (phase_q == PH_REP) begin
						line_d  = 1'b0;
						dur_d   = US_REP_GAP;
						phase_d = phase_q + 7'd1;
					end else if (phase_q == PH_REP_PULSE) begin
						line_d  = 1'b1;
						dur_d   = US_PULSE;
						phase_d = phase_q + 7'd1;
					end else if (phase_q == PH_REP_STOP) begin
						line_d  = 1'b0;
						dur_d   = US_REP_TAIL;
						phase_d = phase_q + 7'd1;
					end else if (phase_q < PH_M_START) begin
						// second repeat tail: line stays released
						dur_d   = US_REP_TAIL;
						phase_d = PH_IDLE;
					end else if (phase_q == PH_M_START) begin
						line_d  = 1'b0;
						dur_d   = US_M_GAP1;
						phase_d = phase_q + 7'd1;
					end else if (phase_q < PH_M_STOP) begin
						line_d  = ~ms[0];
						if (!ms[0])
							dur_d = mbit ? US_M_LOW1 : US_M_LOW0;
						else
							dur_d = mbit ? US_M_GAP1 : US_M_GAP0;
						phase_d = phase_q + 7'd1;
					end else if (phase_q == PH_M_STOP) begin
						line_d  = 1'b1;
						dur_d   = US_M_STOP;
						phase_d = phase_q + 7'd1;
					end else begin
						line_d  = 1'b0;
						dur_d   = US_M_TAIL;
						phase_d = PH_IDLE;
					end
				end
			end
			default: ;
		endcase
	end

	assign res_next = '{line_low: line_d, duration_us: dur_d, timer_run: run_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			pad_code_q    <= '0;
			mouse_frame_q <= '0;
			sum_x_q       <= '0;
			sum_y_q       <= '0;
			buttons_q     <= '0;
			line_q        <= 1'b0;
			dur_q         <= US_RESET;
			run_q         <= 1'b0;
		end else if (take) begin
			phase_q       <= phase_d;
			pad_code_q    <= pad_code_d;
			mouse_frame_q <= mouse_frame_d;
			sum_x_q       <= sum_x_d;
			sum_y_q       <= sum_y_d;
			buttons_q     <= buttons_d;
			line_q        <= line_d;
			dur_q         <= dur_d;
			run_q         <= run_d;
		end
	end

endmodule

// ----- bench/pulse_distance_pad_mouse_encoder_top_test.sv -----
// Self-checking testbench for pulse_distance_pad_mouse_encoder_top.
// Predicts the line level, segment length and timer state for every event item.
// Depends on pdme_pkg and the RTL of the encoder.
module pulse_distance_pad_mouse_encoder_top_test;
	import pdme_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Command code that the block must ignore
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Receiver hold-off used to fill the output and skid stages
	localparam int HOLD_LEN  = 300;
	localparam int SETTLE    = 10;
	localparam int MAX_CYCLES = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic evt_valid = 1'b0;
	logic evt_stall;
	evt_t evt = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	pulse_distance_pad_mouse_encoder_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.evt(evt),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always #10 clk = ~clk;

	// Event items still to be offered, and line segments predicted but not yet seen
	evt_t events_to_send[$];
	res_t segments_due[$];

	int send_idle_pct = 25;
	int recv_idle_pct = 87;
	int mismatches = 0;
	int cycle_count = 0;
	int hold_left = 0;
	logic hold_request = 1'b0;
	logic [5:0] held_pins = 6'h3f;
	res_t want;

	// ------------------------------------------------------------------
	// Encoder state as the testbench sees it (values after reset)
	// ------------------------------------------------------------------
	logic [PHASE_W-1:0]    enc_phase = PH_IDLE;
	logic [PAD_BITS-1:0]   enc_pad = '0;
	logic [MOUSE_BITS-1:0] enc_mframe = '0;
	logic [15:0]           enc_sum_x = '0;
	logic [15:0]           enc_sum_y = '0;
	logic [2:0]            enc_buttons = '0;
	logic                  enc_line = 1'b0;
	logic [DUR_W-1:0]      enc_dur = US_RESET;
	logic                  enc_timer = 1'b0;

	function automatic void set_line(logic low, logic [DUR_W-1:0] us);
		enc_line = low;
		enc_dur = us;
	endfunction

	// +1 and -1 go in whole; anything else is halved toward zero
	function automatic logic [15:0] add_move(logic [15:0] acc, logic signed [7:0] step);
		int v;
		v = step;
		if (v != 1 && v != -1)
			v = v / 2;
		return acc + 16'(v);
	endfunction

	// One segment of the frame state machine
	function automatic void end_segment(logic [5:0] pins);
		logic [5:0] act;
		logic [PAD_BITS-1:0] code;
		logic [15:0] neg_x;
		logic [15:0] neg_y;
		logic [PHASE_W-1:0] s;
		int k;
		logic b;
		if (enc_phase == PH_IDLE) begin
			act = ~pins;
			code = (act != 0) ? (12'h800 | (12'(act) << 2)) : '0;
			if (code != 0 || enc_pad != 0) begin
				// pad has the turn: repeat frame if nothing changed
				enc_phase = (code == enc_pad) ? PH_REP : PH_PAD_START;
				enc_pad = code;
				set_line(1'b1, US_LEADER);
			end else begin
				neg_x = -enc_sum_x;
				neg_y = -enc_sum_y;
				// mouse turn clears the sums even when nothing goes out
				if (enc_buttons != 0 || neg_x[7:0] != 0 || neg_y[7:0] != 0) begin
					enc_mframe = {~enc_buttons, neg_x[7:0], neg_y[7:0]};
					enc_phase = PH_M_START;
					set_line(1'b1, US_M_LEADER);
				end else begin
					enc_timer = 1'b0;
				end
				enc_sum_x = '0;
				enc_sum_y = '0;
				enc_buttons = '0;
			end
		end else if (enc_phase < PH_M_START) begin
			if (enc_phase == PH_PAD_START) begin
				set_line(1'b0, US_LEAD_GAP);
				enc_phase = enc_phase + 7'd1;
			end else if (enc_phase < PH_PAD_END) begin
				s = enc_phase - PH_PAD_BITS;
				if (!s[0]) begin
					set_line(1'b1, US_PULSE);
				end else begin
					k = int'(s >> 1);
					if (k >= PAD_BITS)
						k -= PAD_BITS;
					b = enc_pad[PAD_BITS-1-k];
					// second half of the pad frame carries the inverted code
					if (s > 2 * PAD_BITS)
						b = ~b;
					set_line(1'b0, b ? US_ONE : US_PULSE);
				end
				enc_phase = enc_phase + 7'd1;
			end else if (enc_phase == PH_PAD_END) begin
				set_line(1'b1, US_PULSE);
				enc_phase = enc_phase + 7'd1;
			end else if (enc_phase == PH_PAD_STOP) begin
				set_line(1'b0, US_PAD_TAIL);
				enc_phase = PH_IDLE;
			end else if (enc_phase == PH_REP) begin
				set_line(1'b0, US_REP_GAP);
				enc_phase = enc_phase + 7'd1;
			end else if (enc_phase == PH_REP_PULSE) begin
				set_line(1'b1, US_PULSE);
				enc_phase = enc_phase + 7'd1;
			end else if (enc_phase == PH_REP_STOP) begin
				set_line(1'b0, US_REP_TAIL);
				enc_phase = enc_phase + 7'd1;
			end else begin
				// second repeat tail: length only, line stays
				enc_dur = US_REP_TAIL;
				enc_phase = PH_IDLE;
			end
		end else begin
			if (enc_phase == PH_M_START) begin
				set_line(1'b0, US_M_GAP1);
				enc_phase = enc_phase + 7'd1;
			end else if (enc_phase < PH_M_STOP) begin
				s = enc_phase - PH_M_BITS;
				k = int'(s >> 1);
				b = enc_mframe[MOUSE_BITS-1-k];
				if (!s[0])
					set_line(1'b1, b ? US_M_LOW1 : US_M_LOW0);
				else
					set_line(1'b0, b ? US_M_GAP1 : US_M_GAP0);
				enc_phase = enc_phase + 7'd1;
			end else if (enc_phase == PH_M_STOP) begin
				set_line(1'b1, US_M_STOP);
				enc_phase = enc_phase + 7'd1;
			end else begin
				set_line(1'b0, US_M_TAIL);
				enc_phase = PH_IDLE;
			end
		end
	endfunction

	// Applies one event item and returns the line segment it leads to
	function automatic res_t encode_event(evt_t e);
		res_t r;
		case (e.command)
			CMD_TIMER: begin
				if (enc_timer)
					end_segment(e.joystick_pins);
			end
			CMD_REPORT: begin
				enc_sum_x = add_move(enc_sum_x, e.move_x);
				enc_sum_y = add_move(enc_sum_y, e.move_y);
				enc_buttons = enc_buttons | e.button_bits;
				enc_timer = 1'b1;
			end
			CMD_PINS: begin
				enc_timer = 1'b1;
			end
			default: ;
		endcase
		r.line_low = enc_line;
		r.duration_us = enc_dur;
		r.timer_run = enc_timer;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic logic [7:0] random_move();
		case ($urandom_range(7))
			0: return 8'h01;
			1: return 8'hff;
			2: return 8'h7f;
			3: return 8'h80;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// send queues an item as given; send_loose gives the unused fields random values so that every bit toggles
	function automatic void send(logic [1:0] cmd, logic [5:0] pins, logic [2:0] btn,
			logic [7:0] mx, logic [7:0] my);
		evt_t e;
		e.command = cmd;
		e.joystick_pins = pins;
		e.button_bits = btn;
		e.move_x = mx;
		e.move_y = my;
		events_to_send.push_back(e);
	endfunction

	function automatic void send_loose(logic [1:0] cmd, logic [5:0] pins);
		send(cmd, pins, 3'($urandom_range(7)), random_move(), random_move());
	endfunction

	// Mostly well-formed bursts: a few reports or a pin change, then a run of
	// timer events to carry a frame along; some noise bursts mixed in.
	task automatic queue_random(int n);
		int added;
		int kind;
		int len;
		added = 0;
		while (added < n) begin
			kind = $urandom_range(99);
			if (kind < 12)
				held_pins = ($urandom_range(1) != 0) ? 6'h3f : 6'($urandom_range(63));
			if (kind >= 90) begin
				len = $urandom_range(1, 8);
				repeat (len) begin
					send_loose(2'($urandom_range(3)), 6'($urandom_range(63)));
					if (events_to_send[$].command != CMD_UNUSED)
						added++;
				end
			end else begin
				len = $urandom_range(0, 3);
				repeat (len) begin
					send_loose(CMD_REPORT, 6'($urandom_range(63)));
					added++;
				end
				if ($urandom_range(3) == 0) begin
					send_loose(CMD_PINS, held_pins);
					added++;
				end
				len = $urandom_range(20, 60);
				repeat (len) begin
					// pins only count at idle; an odd glitch elsewhere is harmless
					if ($urandom_range(19) == 0)
						send_loose(CMD_TIMER, 6'($urandom_range(63)));
					else
						send_loose(CMD_TIMER, held_pins);
					added++;
				end
			end
		end
	endtask

	task automatic wait_drained();
		while (events_to_send.size() != 0 || evt_valid || segments_due.size() != 0)
			@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Driver: offers the next pending item; a stalled item is held as is
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid <= 1'b0;
			evt <= '0;
		end else if (!evt_valid || !evt_stall) begin
			// slot frees up at this edge; the current item (if any) is taken
			if (evt_valid)
				segments_due.push_back(encode_event(evt));
			if (events_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				evt <= events_to_send.pop_front();
				evt_valid <= 1'b1;
			end else begin
				evt_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver hold-off, counted on its own
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_request)
			hold_left <= HOLD_LEN;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// ------------------------------------------------------------------
	// Monitor: checks each taken result against the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				if (segments_due.size() == 0) begin
					$error("result with nothing expected: line_low %0b duration_us %0d timer_run %0b",
						res.line_low, res.duration_us, res.timer_run);
					mismatches++;
				end else begin
					want = segments_due.pop_front();
					if (res.line_low !== want.line_low) begin
						$error("line_low: expected %0b, got %0b", want.line_low, res.line_low);
						mismatches++;
					end
					if (res.duration_us !== want.duration_us) begin
						$error("duration_us: expected %0d, got %0d",
							want.duration_us, res.duration_us);
						mismatches++;
					end
					if (res.timer_run !== want.timer_run) begin
						$error("timer_run: expected %0b, got %0b", want.timer_run, res.timer_run);
						mismatches++;
					end
				end
			end
			res_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == MAX_CYCLES) begin
			$display("pulse_distance_pad_mouse_encoder_top_test NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		// Directed: ignored events, mouse turns with nothing to send,
		// extremes of the moves and buttons, then a mouse frame start.
		send(CMD_TIMER, 6'h00, 3'd0, 8'h00, 8'h00);   // timer while stopped
		send(CMD_UNUSED, 6'h3f, 3'd7, 8'hff, 8'hff);  // unused command
		send(CMD_REPORT, 6'h3f, 3'd0, 8'h00, 8'h00);
		send(CMD_TIMER, 6'h3f, 3'd0, 8'h00, 8'h00);   // nothing pending: timer stops
		send(CMD_REPORT, 6'h00, 3'd0, 8'h01, 8'hff);
		send(CMD_REPORT, 6'h3f, 3'd0, 8'hff, 8'h01);
		send(CMD_TIMER, 6'h3f, 3'd7, 8'h7f, 8'h80);   // sums cancel: still no frame
		send(CMD_PINS, 6'h3f, 3'd0, 8'h00, 8'h00);
		send(CMD_REPORT, 6'h00, 3'd7, 8'h7f, 8'h80);
		send(CMD_REPORT, 6'h3f, 3'd0, 8'h80, 8'h7f);
		send(CMD_TIMER, 6'h3f, 3'd0, 8'h00, 8'h00);   // mouse frame starts
		send(CMD_TIMER, 6'h00, 3'd7, 8'hff, 8'hff);   // pins ignored mid-frame
		send(CMD_TIMER, 6'h15, 3'd2, 8'h55, 8'haa);
		send(CMD_PINS, 6'h00, 3'd5, 8'h80, 8'h7f);
		queue_random(500);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// sender mostly busy, receiver mostly stalled
		wait_drained();

		// roles swapped
		send_idle_pct = 87;
		recv_idle_pct = 25;
		queue_random(450);
		wait_drained();

		// no idling; one long receiver hold while items keep coming
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request = 1'b1;
		@(negedge clk);
		hold_request = 1'b0;
		queue_random(60);
		// long run of reports without a segment end: both sums wrap
		repeat (530)
			send(CMD_REPORT, 6'($urandom_range(63)), 3'($urandom_range(7)), 8'h7f, 8'h80);
		queue_random(40);
		wait_drained();

		repeat (SETTLE) @(negedge clk);
		if (mismatches == 0 && segments_due.size() == 0)
			$display("pulse_distance_pad_mouse_encoder_top_test OK");
		else
			$display("pulse_distance_pad_mouse_encoder_top_test NOT OK");
		$finish;
	end

endmodule
